FILE: rtl/smtpcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtpcr_pkg
// Shared types, reply and session codes, and command prefix tables for the
// smtp command recognizer.
// ----------------------------------------------------------------------------
package smtpcr_pkg;

    // session states
    localparam logic [2:0] ST_CLOSED    = 3'd0;
    localparam logic [2:0] ST_CONNECTED = 3'd1;
    localparam logic [2:0] ST_HELLO     = 3'd2;
    localparam logic [2:0] ST_MAIL      = 3'd3;
    localparam logic [2:0] ST_RCPT      = 3'd4;
    localparam logic [2:0] ST_DATA      = 3'd5;
    localparam logic [2:0] ST_BODY      = 3'd6;

    // reply codes
    localparam logic [2:0] RPL_NONE     = 3'd0;
    localparam logic [2:0] RPL_HELLO_OK = 3'd1;
    localparam logic [2:0] RPL_OK       = 3'd2;
    localparam logic [2:0] RPL_START    = 3'd3;
    localparam logic [2:0] RPL_BYE      = 3'd4;
    localparam logic [2:0] RPL_SENT     = 3'd5;
    localparam logic [2:0] RPL_ERROR    = 3'd6;

    // prefix lengths
    localparam logic [3:0] HELLO_LEN = 4'd4;
    localparam logic [3:0] MAIL_LEN  = 4'd9;
    localparam logic [3:0] RCPT_LEN  = 4'd7;
    localparam logic [3:0] DATA_LEN  = 4'd4;
    localparam logic [3:0] QUIT_LEN  = 4'd4;
    localparam logic [3:0] TAIL_LEN  = 4'd3;
    localparam logic [3:0] POS_MAX   = 4'd15;

    // characters
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [23:0] END_OF_BODY = 24'h2E0D0A;

    // per-chunk summary, valid on the last byte of a chunk
    typedef struct packed {
        logic        hello;
        logic        mail;
        logic        rcpt;
        logic        data;
        logic        quit;
        logic [3:0]  len;
        logic [23:0] tail;
    } scan_t;

    // one result word
    typedef struct packed {
        logic [2:0] reply_code;
        logic       body_chunk;
        logic       session_closed;
        logic [2:0] new_session_state;
    } result_t;

    // "MAIL FROM" character at position p
    function automatic logic [7:0] mail_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = 8'h4D;
            4'd1:    c = 8'h41;
            4'd2:    c = 8'h49;
            4'd3:    c = 8'h4C;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h46;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h4F;
            4'd8:    c = 8'h4D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "RCPT TO" character at position p
    function automatic logic [7:0] rcpt_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = 8'h52;
            4'd1:    c = 8'h43;
            4'd2:    c = 8'h50;
            4'd3:    c = 8'h54;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h54;
            4'd6:    c = 8'h4F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "DATA" character at position p
    function automatic logic [7:0] data_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = 8'h44;
            4'd1:    c = 8'h41;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "QUIT" character at position p
    function automatic logic [7:0] quit_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = 8'h51;
            4'd1:    c = 8'h55;
            4'd2:    c = 8'h49;
            4'd3:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/smtpcr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtpcr_in_if
// Byte channel into the recognizer: one received byte and its chunk end flag.
// ----------------------------------------------------------------------------
interface smtpcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

FILE: rtl/smtpcr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtpcr_out_if
// Result channel out of the recognizer: reply code, flags and new state.
// ----------------------------------------------------------------------------
interface smtpcr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] reply_code;
    logic       body_chunk;
    logic       session_closed;
    logic [2:0] new_session_state;

    modport source (output valid, output reply_code, output body_chunk,
                    output session_closed, output new_session_state, input ready);
    modport sink   (input valid, input reply_code, input body_chunk,
                    input session_closed, input new_session_state, output ready);
endinterface

FILE: rtl/smtpcr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtpcr_scan
// Per-chunk byte tracker: position, prefix match flags and last three bytes.
// ----------------------------------------------------------------------------
module smtpcr_scan
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic               chunk_end,
    output smtpcr_pkg::scan_t  summary
);

    logic [3:0]  pos_reg,   pos_next;
    logic        hello_reg, hello_next;
    logic        mail_reg,  mail_next;
    logic        rcpt_reg,  rcpt_next;
    logic        data_reg,  data_next;
    logic        quit_reg,  quit_next;
    logic [23:0] tail_reg,  tail_next;
    logic [7:0]  prev;

    assign prev = tail_reg[7:0];

    // match flags with the current byte folded in
    always_comb
    begin
        hello_next = hello_reg;
        case (pos_reg)
            4'd0:    if (rx_byte != smtpcr_pkg::CH_H && rx_byte != smtpcr_pkg::CH_E)
                         hello_next = 1'b0;
            4'd1:    if (!((prev == smtpcr_pkg::CH_H && rx_byte == smtpcr_pkg::CH_E) ||
                           (prev == smtpcr_pkg::CH_E && rx_byte == smtpcr_pkg::CH_H)))
                         hello_next = 1'b0;
            4'd2:    if (rx_byte != smtpcr_pkg::CH_L)
                         hello_next = 1'b0;
            4'd3:    if (rx_byte != smtpcr_pkg::CH_O)
                         hello_next = 1'b0;
            4'd4:    if (rx_byte != smtpcr_pkg::CH_SPACE)
                         hello_next = 1'b0;
            default: hello_next = hello_reg;
        endcase

        mail_next = mail_reg;
        if (pos_reg < smtpcr_pkg::MAIL_LEN && smtpcr_pkg::mail_char(pos_reg) != rx_byte)
            mail_next = 1'b0;
        rcpt_next = rcpt_reg;
        if (pos_reg < smtpcr_pkg::RCPT_LEN && smtpcr_pkg::rcpt_char(pos_reg) != rx_byte)
            rcpt_next = 1'b0;
        data_next = data_reg;
        if (pos_reg < smtpcr_pkg::DATA_LEN && smtpcr_pkg::data_char(pos_reg) != rx_byte)
            data_next = 1'b0;
        quit_next = quit_reg;
        if (pos_reg < smtpcr_pkg::QUIT_LEN && smtpcr_pkg::quit_char(pos_reg) != rx_byte)
            quit_next = 1'b0;

        tail_next = {tail_reg[15:0], rx_byte};
        pos_next  = (pos_reg == smtpcr_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;
    end

    // summary of the chunk as seen with this byte
    assign summary.hello = hello_next;
    assign summary.mail  = mail_next;
    assign summary.rcpt  = rcpt_next;
    assign summary.data  = data_next;
    assign summary.quit  = quit_next;
    assign summary.len   = pos_next;
    assign summary.tail  = tail_next;

    // tracker registers, cleared after each chunk end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            hello_reg <= 1'b1;
            mail_reg  <= 1'b1;
            rcpt_reg  <= 1'b1;
            data_reg  <= 1'b1;
            quit_reg  <= 1'b1;
            tail_reg  <= 24'd0;
        end
        else if (accept)
        begin
            if (chunk_end)
            begin
                pos_reg   <= 4'd0;
                hello_reg <= 1'b1;
                mail_reg  <= 1'b1;
                rcpt_reg  <= 1'b1;
                data_reg  <= 1'b1;
                quit_reg  <= 1'b1;
                tail_reg  <= 24'd0;
            end
            else
            begin
                pos_reg   <= pos_next;
                hello_reg <= hello_next;
                mail_reg  <= mail_next;
                rcpt_reg  <= rcpt_next;
                data_reg  <= data_next;
                quit_reg  <= quit_next;
                tail_reg  <= tail_next;
            end
        end
    end

endmodule

FILE: rtl/smtpcr_rules.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtpcr_rules
// Session state register and the priority rules applied at each chunk end.
// ----------------------------------------------------------------------------
module smtpcr_rules
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  smtpcr_pkg::scan_t    summary,
    output smtpcr_pkg::result_t  result
);

    logic [2:0] state_reg, state_next;
    logic [2:0] reply;

    // priority rules on the finished chunk
    always_comb
    begin
        state_next = state_reg;
        reply      = smtpcr_pkg::RPL_ERROR;
        if (summary.hello && summary.len >= smtpcr_pkg::HELLO_LEN)
        begin
            state_next = smtpcr_pkg::ST_HELLO;
            reply      = smtpcr_pkg::RPL_HELLO_OK;
        end
        else if (summary.mail && summary.len >= smtpcr_pkg::MAIL_LEN &&
                 state_reg >= smtpcr_pkg::ST_HELLO)
        begin
            state_next = smtpcr_pkg::ST_MAIL;
            reply      = smtpcr_pkg::RPL_OK;
        end
        else if (summary.rcpt && summary.len >= smtpcr_pkg::RCPT_LEN &&
                 state_reg >= smtpcr_pkg::ST_MAIL)
        begin
            state_next = smtpcr_pkg::ST_RCPT;
            reply      = smtpcr_pkg::RPL_OK;
        end
        else if (summary.data && summary.len >= smtpcr_pkg::DATA_LEN &&
                 state_reg >= smtpcr_pkg::ST_RCPT)
        begin
            state_next = smtpcr_pkg::ST_DATA;
            reply      = smtpcr_pkg::RPL_START;
        end
        else if (summary.quit && summary.len >= smtpcr_pkg::QUIT_LEN)
        begin
            state_next = smtpcr_pkg::ST_CLOSED;
            reply      = smtpcr_pkg::RPL_BYE;
        end
        else if (state_reg >= smtpcr_pkg::ST_DATA)
        begin
            state_next = smtpcr_pkg::ST_BODY;
            reply      = (summary.len >= smtpcr_pkg::TAIL_LEN &&
                          summary.tail == smtpcr_pkg::END_OF_BODY) ?
                         smtpcr_pkg::RPL_SENT : smtpcr_pkg::RPL_NONE;
        end
    end

    assign result.reply_code        = reply;
    assign result.body_chunk        = (state_next == smtpcr_pkg::ST_BODY);
    assign result.session_closed    = (state_next == smtpcr_pkg::ST_CLOSED);
    assign result.new_session_state = state_next;

    // session state, kept across chunks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= smtpcr_pkg::ST_CONNECTED;
        else if (commit)
            state_reg <= state_next;
    end

endmodule

FILE: rtl/smtp_command_recognizer_top.sv
`timescale 1ns / 1ps
// a result word is registered and appears in the cycle after the last byte of a chunk is taken
// throughput: one byte per cycle; the result register frees the input side
// as long as the previous result is taken, so bytes keep flowing back to back
// bytes that are not last in a chunk give no result
// reset: session state goes to connected, chunk tracking and output valid clear
// ----------------------------------------------------------------------------
// smtp_command_recognizer_top
// Recognizes smtp commands in received chunks and gives the reply code and
// the new session state for each chunk.
// ----------------------------------------------------------------------------
module smtp_command_recognizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    smtpcr_in_if.sink   cmd,
    smtpcr_out_if.source resp
);

    logic                 accept;
    logic                 commit;
    smtpcr_pkg::scan_t    summary;
    smtpcr_pkg::result_t  result;
    logic                 out_valid_reg;
    smtpcr_pkg::result_t  out_data_reg;

    // input handshake: free when the result register is empty or draining
    assign cmd.ready = !out_valid_reg || resp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign commit    = accept && cmd.chunk_end;

    // byte tracker
    smtpcr_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (cmd.rx_byte),
        .chunk_end (cmd.chunk_end),
        .summary   (summary)
    );

    // session rules
    smtpcr_rules u_rules
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .commit  (commit),
        .summary (summary),
        .result  (result)
    );

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (resp.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (commit)
            out_data_reg <= result;
    end

    assign resp.valid             = out_valid_reg;
    assign resp.reply_code        = out_data_reg.reply_code;
    assign resp.body_chunk        = out_data_reg.body_chunk;
    assign resp.session_closed    = out_data_reg.session_closed;
    assign resp.new_session_state = out_data_reg.new_session_state;

`ifndef SYNTHESIS
    a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("chunk end did not produce a result word");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> out_valid_reg)
        else $error("input stalled with empty result register");

    a_body_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.body_chunk ==
                           (out_data_reg.new_session_state == smtpcr_pkg::ST_BODY)))
        else $error("body flag disagrees with new state");

    a_closed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.session_closed ==
                           (out_data_reg.new_session_state == smtpcr_pkg::ST_CLOSED)))
        else $error("closed flag disagrees with new state");

    a_hello_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.reply_code == smtpcr_pkg::RPL_HELLO_OK) |->
        (out_data_reg.new_session_state == smtpcr_pkg::ST_HELLO))
        else $error("hello reply without hello state");
`endif

endmodule
